// ----- design/itrt_pkg.sv -----
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the integer to radix text core
// Character codes, radix limits, the digit lookup and the character item
// that travels from the sequencer to the word packer.
// ----------------------------------------------------------------------------
package itrt_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CHAR_A     = 8'h61;  // 'a'

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] DEC_DIGITS = 6'd10;

    // One character handed to the packer.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;  // final character of the text
    } t_char_item;

    // Digit value 0..35 to lower-case ASCII.
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_A + {2'b00, d - DEC_DIGITS};
        end
        return c;
    endfunction

endpackage

// ----- design/itrt_in_if.sv -----
// ----------------------------------------------------------------------------
// itrt_in_if: input channel of the integer to radix text core
// Valid/ready handshake carrying one integer and its formatting controls.
// ----------------------------------------------------------------------------
interface itrt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        is_signed;
    logic [5:0]  radix;
    logic [6:0]  min_width;

    modport source (output valid, output value, output is_signed, output radix,
                    output min_width, input ready);
    modport sink   (input valid, input value, input is_signed, input radix,
                    input min_width, output ready);
endinterface

// ----- design/itrt_out_if.sv -----
// ----------------------------------------------------------------------------
// itrt_out_if: output channel of the integer to radix text core
// Valid/ready handshake carrying up to eight packed text characters.
// ----------------------------------------------------------------------------
interface itrt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] text_chars;
    logic [3:0]  char_count;
    logic        last;

    modport source (output valid, output text_chars, output char_count,
                    output last, input ready);
    modport sink   (input valid, input text_chars, input char_count,
                    input last, output ready);
endinterface

// ----- design/itrt_div.sv -----
// ----------------------------------------------------------------------------
// itrt_div: iterative divider by a small radix
// Restoring division, four quotient bits per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module itrt_div
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [((VALUE_BITS + 3) / 4) * 4 - 1:0] i_dividend,
    input  logic [5:0]                           i_radix,
    output logic                                 o_done,
    output logic [((VALUE_BITS + 3) / 4) * 4 - 1:0] o_quot,
    output logic [5:0]                           o_rem
);

    localparam int STEPS = (VALUE_BITS + 3) / 4;
    localparam int DW    = STEPS * 4;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_work;
    logic [5:0]       r_rem;
    logic [5:0]       r_radix;

    logic [DW-1:0]    n_work;
    logic [5:0]       n_rem;

    // Four compare/subtract steps; dividend shifts out the top, quotient in.
    always_comb begin
        logic [6:0] t;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < 4; k++) begin
            t      = {n_rem, n_work[DW-1]};
            n_work = {n_work[DW-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                t         = t - {1'b0, r_radix};
                n_work[0] = 1'b1;
            end
            n_rem = t[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(STEPS);
                r_work  <= i_dividend;
                r_rem   <= '0;
                r_radix <= i_radix;
            end else if (r_busy) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;
    assign o_rem  = r_rem;

endmodule

// ----- design/itrt_pack.sv -----
// ----------------------------------------------------------------------------
// itrt_pack: character to word packer with output register
// Collects characters eight to a word, first character in the top byte.
// ----------------------------------------------------------------------------
module itrt_pack
    import itrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ch_valid,
    input  t_char_item        i_ch,
    output logic              o_ch_ready,
    itrt_out_if.source        o_out
);

    logic [63:0] r_acc;
    logic [2:0]  r_n;
    logic        r_oval;
    logic [63:0] r_text;
    logic [3:0]  r_cnt;
    logic        r_last;

    logic [63:0] n_acc;
    logic        ch_take;
    logic        word_end;

    assign o_ch_ready = !r_oval || o_out.ready;
    assign ch_take    = i_ch_valid && o_ch_ready;
    assign word_end   = (r_n == 3'd7) || i_ch.last;

    always_comb begin
        n_acc = r_acc;
        n_acc[(3'd7 - r_n) * 8 +: 8] = i_ch.ch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_n    <= '0;
            r_oval <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_oval <= 1'b0;
            end
            if (ch_take) begin
                if (word_end) begin
                    r_text <= n_acc;
                    r_cnt  <= {1'b0, r_n} + 4'd1;
                    r_last <= i_ch.last;
                    r_oval <= 1'b1;
                    r_acc  <= '0;
                    r_n    <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_n   <= r_n + 3'd1;
                end
            end
        end
    end

    assign o_out.valid      = r_oval;
    assign o_out.text_chars = r_text;
    assign o_out.char_count = r_cnt;
    assign o_out.last       = r_last;

endmodule

// ----- design/integer_to_radix_text_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_text_core: integer to radix text converter
// Formats one integer as lower-case ASCII in radix 2..36, with optional sign
// and zero padding, and streams it out eight characters to a word.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  takes one item: value, is_signed, radix (2..36, clamped),
//         min_width (0..127, saturated at MAX_TEXT). Ready only while idle.
//   o_out returns 1..16 words per item, first character in bits 63:56,
//         char_count valid characters, last set on the final word.
// Sequence:
//   Each digit is one pass through the shared divider (four quotient bits per
//   cycle), digits counted until the quotient is 0. Emission then reads the
//   digit store and then hands the character to the packer, for each character.
// Stalls: a word waits in the output register; while it waits the packer
//   holds off further characters. The next item can be taken as soon as the
//   last word has reached the output register.
// Reset: synchronous, active low; returns to idle and drops o_out.valid.
// ----------------------------------------------------------------------------
module integer_to_radix_text_core
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_TEXT   = 127
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itrt_in_if.sink    i_in,
    itrt_out_if.source o_out
);

    localparam int STEPS = (VALUE_BITS + 3) / 4;
    localparam int DW    = STEPS * 4;
    localparam int ND_W  = $clog2(VALUE_BITS + 1);
    localparam int IX_W  = $clog2(VALUE_BITS);
    localparam int LEN_W = $clog2(MAX_TEXT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_RD,
        S_PUT
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_mag;     // running quotient
    logic                  r_neg;
    logic [5:0]            r_radix;
    logic [LEN_W-1:0]      r_pad;
    logic [ND_W-1:0]       r_nd;      // digits produced
    logic [LEN_W-1:0]      r_len;     // total characters
    logic [LEN_W-1:0]      r_pos;     // character being emitted
    logic [5:0]            r_rdata;

    // digit store, least significant digit at address 0
    logic [5:0]            r_digits [VALUE_BITS];

    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [5:0]            in_radix;
    logic [LEN_W-1:0]      in_pad;
    logic                  in_take;

    logic                  div_start;
    logic                  div_done;
    logic [DW-1:0]         div_quot;
    logic [5:0]            div_rem;
    logic [VALUE_BITS-1:0] quot;
    logic                  digits_end;
    logic [LEN_W-1:0]      body;
    logic [LEN_W-1:0]      lead;      // sign plus padding characters
    logic [LEN_W-1:0]      rd_full;

    t_char_item            ch_item;
    logic                  ch_valid;
    logic                  ch_ready;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;

    // Operand preparation: mask, sign, magnitude, clamps.
    always_comb begin
        in_val = i_in.value[VALUE_BITS-1:0];
        in_neg = i_in.is_signed && in_val[VALUE_BITS-1];
        if (in_neg) begin
            in_val = ~in_val + VALUE_BITS'(1);
        end
        priority if (i_in.radix < RADIX_MIN) begin
            in_radix = RADIX_MIN;
        end else if (i_in.radix > RADIX_MAX) begin
            in_radix = RADIX_MAX;
        end else begin
            in_radix = i_in.radix;
        end
        if (32'(i_in.min_width) > MAX_TEXT) begin
            in_pad = LEN_W'(MAX_TEXT);
        end else begin
            in_pad = LEN_W'(i_in.min_width);
        end
    end

    assign div_start = (r_state == S_START);

    itrt_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DW'(r_mag)),
        .i_radix    (r_radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign quot       = div_quot[VALUE_BITS-1:0];
    assign digits_end = (quot == '0) || (r_nd == ND_W'(VALUE_BITS - 1));
    assign body       = LEN_W'(r_nd) + LEN_W'(1) + LEN_W'(r_neg);
    assign lead       = r_len - LEN_W'(r_nd);
    assign rd_full    = r_len - LEN_W'(1) - r_pos;

    // Character at r_pos: sign, then zero fill, then digits MSD first.
    always_comb begin
        ch_valid     = (r_state == S_PUT);
        ch_item.last = (r_pos == r_len - LEN_W'(1));
        priority if (r_neg && r_pos == '0) begin
            ch_item.ch = CHAR_MINUS;
        end else if (r_pos < lead) begin
            ch_item.ch = CHAR_ZERO;
        end else begin
            ch_item.ch = digit_char(r_rdata);
        end
    end

    // Digit store: written when a digit comes out of the divider,
    // read into r_rdata in the read state ahead of each character.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_digits[r_nd[IX_W-1:0]] <= div_rem;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_digits[rd_full[IX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nd    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_mag   <= in_val;
                        r_neg   <= in_neg;
                        r_radix <= in_radix;
                        r_pad   <= in_pad;
                        r_nd    <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_nd  <= r_nd + ND_W'(1);
                        r_mag <= quot;
                        if (digits_end) begin
                            r_len   <= (body > r_pad) ? body : r_pad;
                            r_pos   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (ch_ready) begin
                        r_pos   <= r_pos + LEN_W'(1);
                        r_state <= ch_item.last ? S_IDLE : S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    itrt_pack u_pack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch_valid (ch_valid),
        .i_ch       (ch_item),
        .o_ch_ready (ch_ready),
        .o_out      (o_out)
    );

    // A remainder is always a legal digit of the radix.
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |-> (div_rem < r_radix))
        else $error("divider remainder not below radix");

    // Emission never runs past the text length.
    a_pos_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_pos < r_len))
        else $error("character position past text length");

    // Digit count never exceeds the value width.
    a_nd_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_nd < ND_W'(VALUE_BITS)))
        else $error("digit count overflow");

    // The last character leaves the sequencer idle for the next item.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ch_valid && ch_ready && ch_item.last) |=> (r_state == S_IDLE))
        else $error("sequencer not idle after last character");

endmodule

// ----- verif/tb_integer_to_radix_text_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_text_core: testbench for the integer to radix text core
// Drives a directed table and then random items through the input channel.
// The returned text words are checked against literal table words or a behavioral formatter.
// Both sides insert random gaps, and the receiver stalls once for a long
// stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_text_core
    import itrt_pkg::*;
;

    localparam int VALUE_BITS   = 64;
    localparam int MAX_TEXT     = 127;
    localparam int RANDOM_ITEMS = 385;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 400;    // extra wait after the queue empties, to catch stray words
    localparam int LONG_HOLD    = 3000;   // receiver hold-off, in cycles
    localparam int HOLD_AT_WORD = 60;     // word count that triggers the hold-off

    // One text word as the core should return it.
    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  cnt;
        logic        last;
    } t_text_word;

    // One row of the directed table. Rows with known set carry the single
    // text word they produce; the rest go through the formatter.
    typedef struct packed {
        logic [63:0] value;
        logic        sgn;
        logic [5:0]  radix;
        logic [6:0]  pad;
        logic        known;
        logic [63:0] text;
        logic [3:0]  cnt;
    } t_dir_row;

    localparam int DIR_COUNT = 25;
    localparam t_dir_row DIR_ROWS [DIR_COUNT] = '{
        // zero gives a single '0'
        '{64'h0, 1'b0, 6'd10, 7'd0, 1'b1, 64'h3000_0000_0000_0000, 4'd1},
        // zero padded to the widest text: sixteen words
        '{64'h0, 1'b0, 6'd10, 7'd127, 1'b0, 64'h0, 4'd0},
        // all ones, unsigned, binary: 64 digits
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd2, 7'd0, 1'b0, 64'h0, 4'd0},
        // all ones, signed: "-1"
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd10, 7'd0, 1'b1, 64'h2d31_0000_0000_0000, 4'd2},
        // most negative signed value, binary and decimal
        '{64'h8000_0000_0000_0000, 1'b1, 6'd2, 7'd0, 1'b0, 64'h0, 4'd0},
        '{64'h8000_0000_0000_0000, 1'b1, 6'd10, 7'd0, 1'b0, 64'h0, 4'd0},
        // most positive signed value, top radix
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd36, 7'd0, 1'b0, 64'h0, 4'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd36, 7'd0, 1'b0, 64'h0, 4'd0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd10, 7'd0, 1'b0, 64'h0, 4'd0},
        // top digit, hex, octal
        '{64'd35, 1'b0, 6'd36, 7'd0, 1'b1, 64'h7a00_0000_0000_0000, 4'd1},
        '{64'd255, 1'b0, 6'd16, 7'd0, 1'b1, 64'h6666_0000_0000_0000, 4'd2},
        '{64'd8, 1'b0, 6'd8, 7'd0, 1'b1, 64'h3130_0000_0000_0000, 4'd2},
        // radix below two runs as binary
        '{64'd5, 1'b0, 6'd0, 7'd0, 1'b1, 64'h3130_3100_0000_0000, 4'd3},
        '{64'd1, 1'b0, 6'd1, 7'd0, 1'b1, 64'h3100_0000_0000_0000, 4'd1},
        // radix above thirty-six runs as radix 36
        '{64'd35, 1'b0, 6'd63, 7'd0, 1'b1, 64'h7a00_0000_0000_0000, 4'd1},
        '{64'd71, 1'b0, 6'd37, 7'd0, 1'b1, 64'h317a_0000_0000_0000, 4'd2},
        // padding fills exactly one word
        '{64'd7, 1'b0, 6'd10, 7'd8, 1'b1, 64'h3030_3030_3030_3037, 4'd8},
        // padding goes between the sign and the digits
        '{64'hFFFF_FFFF_FFFF_FFFB, 1'b1, 6'd10, 7'd3, 1'b1, 64'h2d30_3500_0000_0000, 4'd3},
        // padding shorter than the text has no effect
        '{64'd12345, 1'b0, 6'd10, 7'd2, 1'b1, 64'h3132_3334_3500_0000, 4'd5},
        // negative value padded to the widest text
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd16, 7'd127, 1'b0, 64'h0, 4'd0},
        // signed read of a positive value
        '{64'd12345, 1'b1, 6'd10, 7'd0, 1'b1, 64'h3132_3334_3500_0000, 4'd5},
        '{64'h5555_5555_5555_5555, 1'b0, 6'd3, 7'd64, 1'b0, 64'h0, 4'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 6'd7, 7'd9, 1'b0, 64'h0, 4'd0},
        // padding equal to the text length
        '{64'd1, 1'b0, 6'd10, 7'd1, 1'b1, 64'h3100_0000_0000_0000, 4'd1},
        '{64'h0123_4567_89ab_cdef, 1'b0, 6'd16, 7'd20, 1'b0, 64'h0, 4'd0}
    };

    logic i_clk;
    logic i_rst_n;

    itrt_in_if  num_ch ();
    itrt_out_if text_ch ();

    integer_to_radix_text_core #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_TEXT   (MAX_TEXT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_ch),
        .o_out   (text_ch)
    );

    // Words still owed by the core, oldest first.
    t_text_word text_words_due [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          calm           = 1'b0;  // no gaps on either side while set

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Formats one number the way the core should and queues the words.
    function automatic void format_number(input logic [63:0] value, input logic sgn,
                                          input logic [5:0] radix, input logic [6:0] pad);
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] d;
        logic        neg;
        logic [7:0]  rev [64];
        logic [7:0]  txt [128];
        int unsigned nd, body, len, width, pos, k, b, cnt;
        t_text_word  w;

        // out-of-range radix clamps to the nearest legal one
        if (radix < RADIX_MIN) begin
            base = 64'(RADIX_MIN);
        end else if (radix > RADIX_MAX) begin
            base = 64'(RADIX_MAX);
        end else begin
            base = 64'(radix);
        end
        width = (pad > MAX_TEXT) ? MAX_TEXT : pad;

        // magnitude of the most negative value wraps back to itself, which
        // is the right unsigned magnitude
        neg = sgn && value[VALUE_BITS-1];
        mag = neg ? (64'd0 - value) : value;

        // digits, least significant first
        nd = 0;
        do begin
            d = mag % base;
            rev[nd] = (d < DEC_DIGITS) ? CHAR_ZERO + d[7:0] : CHAR_A + d[7:0] - 8'(DEC_DIGITS);
            nd++;
            mag = mag / base;
        end while (mag != 0 && nd < 64);

        body = nd + (neg ? 1 : 0);
        len  = (body > width) ? body : width;

        pos = 0;
        if (neg) begin
            txt[pos] = CHAR_MINUS;
            pos++;
        end
        while (pos + nd < len) begin
            txt[pos] = CHAR_ZERO;
            pos++;
        end
        for (k = nd; k > 0; k--) begin
            txt[pos] = rev[k-1];
            pos++;
        end

        // pack eight to a word, first character on top
        for (k = 0; k < len; k += 8) begin
            cnt    = (len - k > 8) ? 8 : len - k;
            w.text = '0;
            for (b = 0; b < cnt; b++) begin
                w.text[63 - 8*b -: 8] = txt[k + b];
            end
            w.cnt  = 4'(cnt);
            w.last = (k + 8 >= len);
            text_words_due.push_back(w);
        end
    endfunction

    // Offers one number after a random gap and returns once it is taken.
    // valid stays high into the next item when there is no gap.
    task automatic offer_number(input logic [63:0] value, input logic sgn,
                                input logic [5:0] radix, input logic [6:0] pad);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            num_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        num_ch.valid     <= 1'b1;
        num_ch.value     <= value;
        num_ch.is_signed <= sgn;
        num_ch.radix     <= radix;
        num_ch.min_width <= pad;
        do @(posedge i_clk); while (!num_ch.ready);
    endtask

    // Receiver: checks every word taken and decides ready for the next edge.
    // After the HOLD_AT_WORD-th word it holds ready low for the LONG_HOLD hold-off
    // while the sender keeps offering, so the core fills and stalls its input.
    initial begin
        int          stall_left;
        int          hold_left;
        int unsigned words_seen;
        bit          hold_done;
        t_text_word  exp_w;

        stall_left    = 0;
        hold_left     = 0;
        words_seen    = 0;
        hold_done     = 1'b0;
        text_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (text_ch.valid && text_ch.ready) begin
                if (text_words_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, got text %h count %0d last %0d",
                             $time, text_ch.text_chars, text_ch.char_count, text_ch.last);
                end else begin
                    exp_w = text_words_due.pop_front();
                    if (text_ch.text_chars !== exp_w.text || text_ch.char_count !== exp_w.cnt
                        || text_ch.last !== exp_w.last) begin
                        mismatch_count++;
                        $display("%0t: word mismatch, expected text %h count %0d last %0d,",
                                 $time, exp_w.text, exp_w.cnt, exp_w.last);
                        $display("%0t:   got text %h count %0d last %0d",
                                 $time, text_ch.text_chars, text_ch.char_count, text_ch.last);
                    end
                end
                words_seen++;
                stall_left = calm ? 0 : $urandom_range(0, 3);
                if (words_seen == HOLD_AT_WORD && !hold_done) begin
                    hold_left = LONG_HOLD;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                text_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                text_ch.ready <= 1'b0;
            end else begin
                text_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [63:0] value;
        logic        sgn;
        logic [5:0]  radix;
        logic [6:0]  pad;

        i_rst_n          <= 1'b0;
        num_ch.valid     <= 1'b0;
        num_ch.value     <= '0;
        num_ch.is_signed <= 1'b0;
        num_ch.radix     <= RADIX_MIN;
        num_ch.min_width <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: literal words where obvious, formatter elsewhere
        for (int r = 0; r < DIR_COUNT; r++) begin
            offer_number(DIR_ROWS[r].value, DIR_ROWS[r].sgn, DIR_ROWS[r].radix,
                         DIR_ROWS[r].pad);
            if (DIR_ROWS[r].known) begin
                text_words_due.push_back('{DIR_ROWS[r].text, DIR_ROWS[r].cnt, 1'b1});
            end else begin
                format_number(DIR_ROWS[r].value, DIR_ROWS[r].sgn, DIR_ROWS[r].radix,
                              DIR_ROWS[r].pad);
            end
        end

        // random part; a middle stretch runs back to back on both sides
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 150 && n < 200);
            case ($urandom_range(0, 9))
                0: value = '1;
                1: value = 64'h8000_0000_0000_0000;
                2: value = 64'($urandom_range(0, 40));
                default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            sgn   = 1'($urandom_range(0, 1));
            radix = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(2, 36));
            case ($urandom_range(0, 7))
                0:       pad = 7'($urandom_range(0, 127));
                1, 2, 3: pad = 7'($urandom_range(0, 30));
                default: pad = '0;
            endcase
            offer_number(value, sgn, radix, pad);
            format_number(value, sgn, radix, pad);
        end
        calm = 1'b0;
        num_ch.valid <= 1'b0;

        // every item yields at least one word, so an empty queue means done;
        // the extra cycles catch any stray words
        while (text_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/itrt_pkg.sv
design/itrt_in_if.sv
design/itrt_out_if.sv
design/itrt_div.sv
design/itrt_pack.sv
design/integer_to_radix_text_core.sv
verif/tb_integer_to_radix_text_core.sv
